>>> design/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk once reset is released.
`define ASSERT_CLK(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed while out of reset");

// Check a property on every rising edge of clk, reset included.
`define ASSERT_CLK_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("assertion failed");

`endif

>>> design/berc_pkg.sv
// ----------------------------------------------------------------------------
// berc_pkg
// Types and constants shared by the block extent run coalescer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package berc_pkg;

	localparam int OFF_W      = 63;
	localparam int ADDR_W     = 48;
	localparam int BSIZE_W    = 21;
	localparam int BYTES_W    = 24;
	localparam int KIND_W     = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 63;

	localparam int ADDR_BITS_DEF = 48;

	localparam logic [BSIZE_W-1:0] BSIZE_RESET = BSIZE_W'(4096);
	localparam logic [OFF_W-1:0]   OFF_MAX     = '1;

	// Kind mask bit positions
	localparam int KIND_RAW    = 0;
	localparam int KIND_SPARSE = 1;
	localparam int KIND_COMP   = 2;

	typedef enum logic {
		CMD_BLOCK = 1'b0,
		CMD_END   = 1'b1
	} berc_cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BLOCK_SIZE      = 1'b0,
		REG_PARTITION_START = 1'b1
	} berc_reg_t;

	typedef struct packed {
		berc_cmd_t           command;
		logic [OFF_W-1:0]    block_file_offset;
		logic [ADDR_W-1:0]   block_address;
		logic [BYTES_W-1:0]  block_bytes;
		logic [KIND_W-1:0]   block_kind;
	} berc_in_t;

	typedef struct packed {
		logic [OFF_W-1:0]  run_file_offset;
		logic [OFF_W-1:0]  run_fs_offset;
		logic [OFF_W-1:0]  run_img_offset;
		logic [OFF_W-1:0]  run_length;
		logic [KIND_W-1:0] run_kind;
	} berc_out_t;

	// Block event with its offsets resolved
	typedef struct packed {
		berc_cmd_t          cmd;
		logic [OFF_W-1:0]   foff;
		logic [BYTES_W-1:0] bytes;
		logic [KIND_W-1:0]  kind;
		logic [OFF_W-1:0]   fs_off;
		logic [OFF_W-1:0]   img_off;
	} berc_item_t;

endpackage

`default_nettype wire

>>> design/berc_offset.sv
// ----------------------------------------------------------------------------
// berc_offset
// Input register, block address times block size, and partition start add.
// Holds the two configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module berc_offset import berc_pkg::*; #(
	parameter int ADDR_BITS = ADDR_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  blk_valid,
	output logic                       blk_ready,
	input  wire berc_in_t              blk,
	output logic                       item_valid,
	input  wire logic                  item_ready,
	output berc_item_t                 item
);

	localparam int USE_BITS = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
	localparam int PROD_W   = USE_BITS + BSIZE_W;
	localparam int MUL_W    = (PROD_W > OFF_W) ? PROD_W : OFF_W;

	logic [BSIZE_W-1:0] bsize_q;
	logic [OFF_W-1:0]   pstart_q;

	logic       v_s1, v_s2, v_s3;
	logic       adv_s1, adv_s2, adv_s3;
	berc_in_t   blk_s1;
	berc_item_t it_s2, it_s3;

	logic [USE_BITS-1:0] addr_use;
	logic [MUL_W-1:0]    prod;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bsize_q  <= BSIZE_RESET;
			pstart_q <= '0;
		end else if (cfg_we) begin
			case (berc_reg_t'(cfg_index))
				REG_BLOCK_SIZE:      bsize_q  <= cfg_data[BSIZE_W-1:0];
				REG_PARTITION_START: pstart_q <= cfg_data[OFF_W-1:0];
				default: ;
			endcase
		end
	end

	// Advance a stage when it is empty or its content moves on
	assign adv_s3    = !v_s3 || item_ready;
	assign adv_s2    = !v_s2 || adv_s3;
	assign adv_s1    = !v_s1 || adv_s2;
	assign blk_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= blk_valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
		end
	end

	// Filesystem offset: low address bits times block size, wrapped to 63 bits
	assign addr_use = blk_s1.block_address[USE_BITS-1:0];
	assign prod     = MUL_W'(addr_use) * MUL_W'(bsize_q);

	// Hold the payload of each stage
	always_ff @(posedge clk) begin
		if (adv_s1) blk_s1 <= blk;
		if (adv_s2) begin
			it_s2.cmd     <= blk_s1.command;
			it_s2.foff    <= blk_s1.block_file_offset;
			it_s2.bytes   <= blk_s1.block_bytes;
			it_s2.kind    <= blk_s1.block_kind;
			it_s2.fs_off  <= prod[OFF_W-1:0];
			it_s2.img_off <= '0;
		end
		if (adv_s3) begin
			it_s3.cmd     <= it_s2.cmd;
			it_s3.foff    <= it_s2.foff;
			it_s3.bytes   <= it_s2.bytes;
			it_s3.kind    <= it_s2.kind;
			it_s3.fs_off  <= it_s2.fs_off;
			it_s3.img_off <= pstart_q + it_s2.fs_off;
		end
	end

	assign item_valid = v_s3;
	assign item       = it_s3;

endmodule

`default_nettype wire

>>> design/berc_merge.sv
// ----------------------------------------------------------------------------
// berc_merge
// Open run registers, extend decision and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module berc_merge import berc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       item_valid,
	output logic            item_ready,
	input  wire berc_item_t item,
	output logic            run_valid,
	input  wire logic       run_ready,
	output berc_out_t       run
);

	logic               open_v_q;
	logic [OFF_W-1:0]   file_q, fs_q, img_q, len_q;
	logic [KIND_W-1:0]  kind_q;
	// Run end positions and start minus one, kept so the decision needs no chained adds
	logic [OFF_W-1:0]   end_file_q, end_img_q, file_m1_q, img_m1_q;

	logic               out_v_q;
	berc_out_t          out_q;

	logic               is_end, is_zero, follow, img_next, extend, emit, slot_free, take;
	logic [OFF_W-1:0]   bytes_x;
	logic [OFF_W:0]     len_sum;
	logic               sat;

	// Decide whether the beat extends the open run
	always_comb begin
		is_end   = (item.cmd == CMD_END);
		is_zero  = (item.bytes == '0);
		follow   = open_v_q && (end_file_q == item.foff);
		img_next = (end_img_q == item.img_off);
		extend   = follow && (
			(kind_q[KIND_SPARSE] && item.kind[KIND_SPARSE]) ||
			(img_next && kind_q[KIND_COMP] && item.kind[KIND_COMP]) ||
			(img_next && kind_q[KIND_RAW] && item.kind[KIND_RAW]));
		emit     = is_end ? open_v_q : (!is_zero && !extend && open_v_q);
	end

	assign slot_free  = !out_v_q || run_ready;
	assign item_ready = !emit || slot_free;
	assign take       = item_valid && item_ready;

	assign bytes_x = OFF_W'(item.bytes);
	assign len_sum = (OFF_W+1)'(len_q) + (OFF_W+1)'(item.bytes);
	assign sat     = len_sum[OFF_W];

	// Update the open run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_v_q <= 1'b0;
		end else if (take) begin
			if (is_end) begin
				open_v_q <= 1'b0;
			end else if (!is_zero && !extend) begin
				open_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && !is_end && !is_zero) begin
			if (extend) begin
				len_q      <= sat ? OFF_MAX : len_sum[OFF_W-1:0];
				end_file_q <= sat ? file_m1_q : end_file_q + bytes_x;
				end_img_q  <= sat ? img_m1_q : end_img_q + bytes_x;
			end else begin
				file_q     <= item.foff;
				fs_q       <= item.fs_off;
				img_q      <= item.img_off;
				len_q      <= bytes_x;
				kind_q     <= item.kind;
				end_file_q <= item.foff + bytes_x;
				end_img_q  <= item.img_off + bytes_x;
				file_m1_q  <= item.foff - OFF_W'(1);
				img_m1_q   <= item.img_off - OFF_W'(1);
			end
		end
	end

	// Result register: load on emit, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (take && emit) begin
			out_v_q <= 1'b1;
		end else if (run_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			out_q.run_file_offset <= file_q;
			out_q.run_fs_offset   <= fs_q;
			out_q.run_img_offset  <= img_q;
			out_q.run_length      <= len_q;
			out_q.run_kind        <= kind_q;
		end
	end

	assign run_valid = out_v_q;
	assign run       = out_q;

endmodule

`default_nettype wire

>>> design/block_extent_run_coalescer_unit.sv
// ----------------------------------------------------------------------------
// block_extent_run_coalescer_unit
// Merges block events into file-contiguous runs, image-contiguous unless sparse.
// ----------------------------------------------------------------------------
// One block event or end command is accepted per clock when blk_ready is high.
// A beat passes the input register, the address times block size register and
// the partition start adder register; the decision against the single open run
// then loads any run it ends into the result register, using end offsets kept
// precomputed so it needs no chained adds. Input ready drops only while a run
// waits in the result register and the next event would emit another.
// The user must write configuration while idle; the block does not enforce it.
`default_nettype none

module block_extent_run_coalescer_unit import berc_pkg::*; #(
	parameter int ADDR_BITS = ADDR_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  blk_valid,
	output logic                       blk_ready,
	input  wire berc_in_t              blk,
	output logic                       run_valid,
	input  wire logic                  run_ready,
	output berc_out_t                  run
);

	logic       item_valid;
	logic       item_ready;
	berc_item_t item;

	// Offset pipeline
	berc_offset #(
		.ADDR_BITS(ADDR_BITS)
	) u_offset (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.blk_valid  (blk_valid),
		.blk_ready  (blk_ready),
		.blk        (blk),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item)
	);

	// Run merge and result register
	berc_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.run_valid  (run_valid),
		.run_ready  (run_ready),
		.run        (run)
	);

endmodule

`default_nettype wire

>>> design/berc_checker.sv
// ----------------------------------------------------------------------------
// berc_checker
// Port-level checks on the coalescer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module berc_checker import berc_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      blk_ready,
	input wire logic      run_valid,
	input wire logic      run_ready,
	input wire berc_out_t run
);

	localparam logic [OFF_W-1:0] BLOCK_LIMIT = OFF_W'(1) << BYTES_W;

	logic plain_kind;

	// A kind with no raw, sparse or compressed bit
	assign plain_kind = !run.run_kind[KIND_RAW] && !run.run_kind[KIND_SPARSE]
		&& !run.run_kind[KIND_COMP];

	// Hold a stalled result beat
	`ASSERT_CLK(a_run_hold, run_valid && !run_ready |=> run_valid && $stable(run))

	// Every run holds at least one nonempty block
	`ASSERT_CLK(a_run_nonempty, run_valid |-> run.run_length != '0)

	// Blocks with no mergeable kind form single-block runs
	`ASSERT_CLK(a_single_block, run_valid && plain_kind |-> run.run_length < BLOCK_LIMIT)

	// Input stalls only behind a waiting result
	`ASSERT_CLK(a_stall_cause, !blk_ready |-> run_valid)

endmodule

bind block_extent_run_coalescer_unit berc_checker u_berc_checker (.*);

`default_nettype wire
